FILE: sv/spfa_pkg.sv
package spfa_pkg;

	localparam int NODE_W   = 6;
	localparam int NODES    = 64;
	localparam int CNT_W    = 7;
	localparam int EDGES    = 256;
	localparam int EADDR_W  = 8;
	localparam int ECNT_W   = 9;
	localparam int WEIGHT_W = 16;
	localparam int DIST_W   = 32;
	localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;
	localparam int NODE_WORD_W = NODE_W + DIST_W;

	localparam logic [CNT_W-1:0] NODE_CNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NEG_CYC = 2'd1,
		ST_FULL    = 2'd2,
		ST_BAD_IDX = 2'd3
	} status_t;

endpackage

FILE: sv/spfa_if.sv
interface spfa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [5:0]  node_a;
	logic [5:0]  node_b;
	logic signed [15:0] weight;

	modport source (output valid, cmd, node_a, node_b, weight, input ready);
	modport sink   (input valid, cmd, node_a, node_b, weight, output ready);
endinterface

interface spfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        reachable;
	logic signed [31:0] distance;
	logic        has_pred;
	logic [5:0]  pred_node;

	modport source (output valid, status, reachable, distance, has_pred, pred_node,
		input ready);
	modport sink   (input valid, status, reachable, distance, has_pred, pred_node,
		output ready);
endinterface

FILE: sv/spfa_ram.sv
module spfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/spfa_shortest_path_engine.sv
// Clear and add-edge words post their result when taken; a read passes through
// the read state first. A run holds the request side until it ends: it starts,
// then for each node popped from the work list it steps through pop, fetch and
// distance load and goes back to pop when the node is skipped (not reached or
// not in use), or else reads and checks every stored edge and relaxes each edge
// from that node to a node in use; it posts the result when the list is empty.
// A negative cycle ends the run at the relax step that finds it. No clearing
// pass runs after reset.
module spfa_shortest_path_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [6:0]       cfg_wdata,
	spfa_req_if.sink         req,
	spfa_rsp_if.source       rsp
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RD   = 8'b0000_0010,
		S_POP  = 8'b0000_0100,
		S_POPU = 8'b0000_1000,
		S_LDDU = 8'b0001_0000,
		S_ERD  = 8'b0010_0000,
		S_ECHK = 8'b0100_0000,
		S_RLX  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [spfa_pkg::CNT_W-1:0]  ncfg_q;
	logic [spfa_pkg::CNT_W-1:0]  n_eff;
	logic [spfa_pkg::ECNT_W-1:0] edges_q;
	logic [spfa_pkg::ECNT_W-1:0] e_q;
	logic [spfa_pkg::NODES-1:0]  reached_q, predv_q, queued_q, touched_q, mask;
	logic [spfa_pkg::NODE_W-1:0] head_q, tail_q, u_q, v_q, a_q;
	logic [spfa_pkg::CNT_W-1:0]  fill_q;
	logic signed [spfa_pkg::DIST_W-1:0]   du_q;
	logic signed [spfa_pkg::WEIGHT_W-1:0] w_q;

	logic ov_q, reach_q, hp_q;
	logic [1:0] status_q;
	logic signed [spfa_pkg::DIST_W-1:0] dist_q;
	logic [spfa_pkg::NODE_W-1:0] pn_q;

	// ram ports
	logic edge_we;
	logic [spfa_pkg::EDGE_W-1:0] edge_rdata;
	logic node_we;
	logic [spfa_pkg::NODE_W-1:0] node_waddr, node_raddr;
	logic [spfa_pkg::NODE_WORD_W-1:0] node_wdata, node_rdata;
	logic fifo_we;
	logic [spfa_pkg::NODE_W-1:0] fifo_waddr, fifo_wdata, fifo_rdata;
	logic [spfa_pkg::CNT_W-1:0] cnt_rdata, cnt_new;

	logic acc, a_bad, b_bad, run_go, out_free, res_set;
	logic [spfa_pkg::NODE_W-1:0] e_src, e_dst;
	logic signed [spfa_pkg::WEIGHT_W-1:0] e_w;
	logic signed [spfa_pkg::DIST_W:0] sum;
	logic signed [spfa_pkg::DIST_W-1:0] cand, dist_v;
	logic improve, push_cnt, push, neg;

	// clamp node count
	always_comb begin
		if (ncfg_q == '0) begin
			n_eff = spfa_pkg::CNT_W'(1);
		end else if (ncfg_q > spfa_pkg::CNT_W'(spfa_pkg::NODES)) begin
			n_eff = spfa_pkg::CNT_W'(spfa_pkg::NODES);
		end else begin
			n_eff = ncfg_q;
		end
	end

	// nodes in use
	always_comb begin
		for (int i = 0; i < spfa_pkg::NODES; i++) begin
			mask[i] = (spfa_pkg::CNT_W'(i) < n_eff);
		end
	end

	assign out_free  = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign a_bad     = {1'b0, req.node_a} >= n_eff;
	assign b_bad     = {1'b0, req.node_b} >= n_eff;
	assign run_go    = acc && (req.cmd == spfa_pkg::CMD_RUN) && !a_bad;
	assign edge_we   = acc && (req.cmd == spfa_pkg::CMD_ADD) && !a_bad && !b_bad
		&& (edges_q < spfa_pkg::ECNT_W'(spfa_pkg::EDGES));

	assign e_src = edge_rdata[spfa_pkg::EDGE_W-1 -: spfa_pkg::NODE_W];
	assign e_dst = edge_rdata[spfa_pkg::WEIGHT_W +: spfa_pkg::NODE_W];
	assign e_w   = edge_rdata[spfa_pkg::WEIGHT_W-1:0];

	// saturating relax sum
	assign dist_v = node_rdata[spfa_pkg::DIST_W-1:0];
	assign sum = {du_q[spfa_pkg::DIST_W-1], du_q}
		+ (spfa_pkg::DIST_W+1)'(w_q);
	always_comb begin
		if (sum[spfa_pkg::DIST_W] != sum[spfa_pkg::DIST_W-1]) begin
			cand = sum[spfa_pkg::DIST_W] ? {1'b1, {(spfa_pkg::DIST_W-1){1'b0}}}
				: {1'b0, {(spfa_pkg::DIST_W-1){1'b1}}};
		end else begin
			cand = sum[spfa_pkg::DIST_W-1:0];
		end
	end

	assign improve  = (state_q == S_RLX) && (!reached_q[v_q] || (dist_v > cand));
	assign push_cnt = improve && !queued_q[v_q];
	assign push     = push_cnt && (fill_q < spfa_pkg::CNT_W'(spfa_pkg::NODES));
	assign cnt_new  = (touched_q[v_q] ? cnt_rdata : '0) + spfa_pkg::CNT_W'(1);
	assign neg      = push_cnt && (cnt_new >= n_eff);

	// post a result word
	assign res_set = ((state_q == S_IDLE) && acc && (a_bad
			|| ((req.cmd != spfa_pkg::CMD_RUN) && (req.cmd != spfa_pkg::CMD_READ))))
		|| (state_q == S_RD)
		|| ((state_q == S_POP) && (fill_q == '0))
		|| neg;

	// ram port steering
	always_comb begin
		node_we    = run_go || improve;
		node_waddr = run_go ? req.node_a : v_q;
		node_wdata = run_go ? '0 : {u_q, cand};
		fifo_we    = run_go || push;
		fifo_waddr = run_go ? '0 : tail_q;
		fifo_wdata = run_go ? req.node_a : v_q;
		unique case (state_q)
			S_IDLE:  node_raddr = req.node_a;
			S_POPU:  node_raddr = fifo_rdata;
			S_ECHK:  node_raddr = e_dst;
			default: node_raddr = v_q;
		endcase
	end

	spfa_ram #(.WIDTH(spfa_pkg::EDGE_W), .DEPTH(spfa_pkg::EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (edge_we),
		.waddr (edges_q[spfa_pkg::EADDR_W-1:0]),
		.wdata ({req.node_a, req.node_b, req.weight}),
		.raddr (e_q[spfa_pkg::EADDR_W-1:0]),
		.rdata (edge_rdata)
	);

	spfa_ram #(.WIDTH(spfa_pkg::NODE_WORD_W), .DEPTH(spfa_pkg::NODES)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	spfa_ram #(.WIDTH(spfa_pkg::NODE_W), .DEPTH(spfa_pkg::NODES)) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	spfa_ram #(.WIDTH(spfa_pkg::CNT_W), .DEPTH(spfa_pkg::NODES)) u_cnt_ram (
		.clk   (clk),
		.we    (push_cnt),
		.waddr (v_q),
		.wdata (cnt_new),
		.raddr (e_dst),
		.rdata (cnt_rdata)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= spfa_pkg::NODE_CNT_RESET;
		end else if (cfg_we) begin
			ncfg_q <= cfg_wdata;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_set) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			edges_q   <= '0;
			e_q       <= '0;
			reached_q <= '0;
			predv_q   <= '0;
			queued_q  <= '0;
			touched_q <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						a_q      <= req.node_a;
						reach_q  <= 1'b0;
						dist_q   <= '0;
						hp_q     <= 1'b0;
						pn_q     <= '0;
						case (req.cmd)
							spfa_pkg::CMD_CLEAR: begin
								status_q <= spfa_pkg::ST_OK;
								edges_q  <= '0;
							end
							spfa_pkg::CMD_ADD: begin
								if (a_bad || b_bad) begin
									status_q <= spfa_pkg::ST_BAD_IDX;
								end else if (!edge_we) begin
									status_q <= spfa_pkg::ST_FULL;
								end else begin
									status_q <= spfa_pkg::ST_OK;
									edges_q  <= edges_q + spfa_pkg::ECNT_W'(1);
								end
							end
							spfa_pkg::CMD_RUN: begin
								if (a_bad) begin
									status_q <= spfa_pkg::ST_BAD_IDX;
								end else begin
									status_q  <= spfa_pkg::ST_OK;
									reached_q <= (reached_q & ~mask)
										| (spfa_pkg::NODES'(1) << req.node_a);
									queued_q  <= (queued_q & ~mask)
										| (spfa_pkg::NODES'(1) << req.node_a);
									predv_q   <= predv_q & ~mask;
									touched_q <= touched_q & ~mask;
									head_q    <= '0;
									tail_q    <= spfa_pkg::NODE_W'(1);
									fill_q    <= spfa_pkg::CNT_W'(1);
									state_q   <= S_POP;
								end
							end
							default: begin
								if (a_bad) begin
									status_q <= spfa_pkg::ST_BAD_IDX;
								end else begin
									status_q <= spfa_pkg::ST_OK;
									state_q  <= S_RD;
								end
							end
						endcase
					end
				end
				S_RD: begin
					reach_q <= reached_q[a_q];
					dist_q  <= reached_q[a_q] ? dist_v : '0;
					hp_q    <= predv_q[a_q];
					pn_q    <= predv_q[a_q]
						? node_rdata[spfa_pkg::NODE_WORD_W-1 -: spfa_pkg::NODE_W] : '0;
					state_q <= S_IDLE;
				end
				S_POP: begin
					if (fill_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						head_q  <= head_q + spfa_pkg::NODE_W'(1);
						fill_q  <= fill_q - spfa_pkg::CNT_W'(1);
						state_q <= S_POPU;
					end
				end
				S_POPU: begin
					u_q <= fifo_rdata;
					queued_q[fifo_rdata] <= 1'b0;
					state_q <= S_LDDU;
				end
				S_LDDU: begin
					du_q <= dist_v;
					e_q  <= '0;
					state_q <= (reached_q[u_q] && mask[u_q]) ? S_ERD : S_POP;
				end
				S_ERD: begin
					state_q <= (e_q == edges_q) ? S_POP : S_ECHK;
				end
				S_ECHK: begin
					v_q <= e_dst;
					w_q <= e_w;
					e_q <= e_q + spfa_pkg::ECNT_W'(1);
					state_q <= ((e_src == u_q) && mask[e_dst]) ? S_RLX : S_ERD;
				end
				S_RLX: begin
					state_q <= neg ? S_IDLE : S_ERD;
					if (improve) begin
						reached_q[v_q] <= 1'b1;
						predv_q[v_q]   <= 1'b1;
						if (v_q == u_q) begin
							du_q <= cand;
						end
					end
					if (push_cnt) begin
						touched_q[v_q] <= 1'b1;
					end
					if (push) begin
						queued_q[v_q] <= 1'b1;
						tail_q <= tail_q + spfa_pkg::NODE_W'(1);
						fill_q <= fill_q + spfa_pkg::CNT_W'(1);
					end
					if (neg) begin
						status_q <= spfa_pkg::ST_NEG_CYC;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.status    = status_q;
	assign rsp.reachable = reach_q;
	assign rsp.distance  = dist_q;
	assign rsp.has_pred  = hp_q;
	assign rsp.pred_node = pn_q;

	// checks
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (state_q == S_IDLE))
		else $error("request taken outside idle");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= spfa_pkg::CNT_W'(spfa_pkg::NODES))
		else $error("work list overfilled");

	a_read_path: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (req.cmd == spfa_pkg::CMD_READ) && !a_bad) |=> (state_q == S_RD))
		else $error("read did not enter read state");

endmodule

FILE: verif/spfa_shortest_path_engine_tb.sv
module spfa_shortest_path_engine_tb;

	typedef struct {
		spfa_pkg::status_t  st;
		bit                 reach;
		logic signed [31:0] dval;
		bit                 hp;
		bit [5:0]           pn;
	} path_rsp_t;

	localparam int WATCHDOG_CYCLES = 10000000;
	localparam longint DIST_HI = 64'sd2147483647;
	localparam longint DIST_LO = -64'sd2147483648;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_wdata;

	spfa_req_if req ();
	spfa_rsp_if rsp ();

	spfa_shortest_path_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req.sink),
		.rsp       (rsp.source)
	);

	// shadow of the engine state
	bit [6:0]        node_cnt;
	bit [5:0]        edge_src [spfa_pkg::EDGES];
	bit [5:0]        edge_dst [spfa_pkg::EDGES];
	shortint         edge_wt [spfa_pkg::EDGES];
	int              edge_total;
	longint          node_dist [spfa_pkg::NODES];
	bit              node_reach [spfa_pkg::NODES];
	bit [5:0]        node_prev [spfa_pkg::NODES];
	bit              node_prev_ok [spfa_pkg::NODES];
	int              push_count [spfa_pkg::NODES];
	bit              in_list [spfa_pkg::NODES];
	int              work_list [spfa_pkg::NODES];
	int              wl_head, wl_tail, wl_fill;

	path_rsp_t       expected_rsp [$];
	int              errors;
	int              words_sent;
	int              idle_cycles;
	int              rsp_hold;
	bit              calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_nodes();
		if (node_cnt == 0) return 1;
		if (node_cnt > spfa_pkg::NODES) return spfa_pkg::NODES;
		return node_cnt;
	endfunction

	function automatic longint sat_add(longint d, longint w);
		longint s;
		s = d + w;
		if (s > DIST_HI) return DIST_HI;
		if (s < DIST_LO) return DIST_LO;
		return s;
	endfunction

	function automatic void list_push(int v);
		if (wl_fill >= spfa_pkg::NODES) return;
		work_list[wl_tail] = v;
		wl_tail = (wl_tail + 1) % spfa_pkg::NODES;
		wl_fill++;
		in_list[v] = 1'b1;
	endfunction

	// queue-based relaxation from start; returns the run status
	function automatic spfa_pkg::status_t relax_from(int start, int n);
		int u, v;
		longint cand;
		for (int i = 0; i < n; i++) begin
			node_reach[i] = 1'b0;
			node_prev_ok[i] = 1'b0;
			push_count[i] = 0;
			in_list[i] = 1'b0;
		end
		wl_head = 0;
		wl_tail = 0;
		wl_fill = 0;
		node_dist[start] = 0;
		node_reach[start] = 1'b1;
		list_push(start);
		while (wl_fill > 0) begin
			u = work_list[wl_head];
			wl_head = (wl_head + 1) % spfa_pkg::NODES;
			wl_fill--;
			in_list[u] = 1'b0;
			if (u >= n || !node_reach[u]) continue;
			for (int e = 0; e < edge_total; e++) begin
				v = edge_dst[e];
				if (edge_src[e] != u || v >= n) continue;
				cand = sat_add(node_dist[u], edge_wt[e]);
				if (node_reach[v] && node_dist[v] <= cand) continue;
				node_dist[v] = cand;
				node_reach[v] = 1'b1;
				node_prev[v] = u;
				node_prev_ok[v] = 1'b1;
				if (!in_list[v]) begin
					list_push(v);
					push_count[v]++;
					if (push_count[v] >= n) return spfa_pkg::ST_NEG_CYC;
				end
			end
		end
		return spfa_pkg::ST_OK;
	endfunction

	function automatic path_rsp_t predict_path(spfa_pkg::cmd_t c, int a, int b, int w);
		path_rsp_t r;
		int n;
		n = active_nodes();
		r.st = spfa_pkg::ST_OK;
		r.reach = 1'b0;
		r.dval = '0;
		r.hp = 1'b0;
		r.pn = '0;
		case (c)
			spfa_pkg::CMD_CLEAR: edge_total = 0;
			spfa_pkg::CMD_ADD: begin
				if (a >= n || b >= n) r.st = spfa_pkg::ST_BAD_IDX;
				else if (edge_total >= spfa_pkg::EDGES) r.st = spfa_pkg::ST_FULL;
				else begin
					edge_src[edge_total] = a;
					edge_dst[edge_total] = b;
					edge_wt[edge_total] = w;
					edge_total++;
				end
			end
			spfa_pkg::CMD_RUN: begin
				if (a >= n) r.st = spfa_pkg::ST_BAD_IDX;
				else r.st = relax_from(a, n);
			end
			default: begin
				if (a >= n) r.st = spfa_pkg::ST_BAD_IDX;
				else begin
					if (node_reach[a]) begin
						r.reach = 1'b1;
						r.dval = node_dist[a];
					end
					if (node_prev_ok[a]) begin
						r.hp = 1'b1;
						r.pn = node_prev[a];
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one word; valid stays high for a back-to-back follower
	task automatic send_word(spfa_pkg::cmd_t c, int a, int b, int w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.cmd = c;
		req.node_a = a;
		req.node_b = b;
		req.weight = w;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		expected_rsp.insert(expected_rsp.size(), predict_path(c, a, b, w));
		words_sent++;
		@(negedge clk);
	endtask

	// hold the sender until every result is back
	task automatic drain();
		req.valid = 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_nodes(bit [6:0] v);
		drain();
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		node_cnt = v;
	endtask

	// response stall pattern
	always @(negedge clk) begin
		if (calm) begin
			rsp.ready = 1'b1;
		end else if (rsp_hold > 0) begin
			rsp_hold--;
			rsp.ready = 1'b0;
		end else begin
			rsp.ready = 1'b1;
			if ($urandom_range(0, 99) < 25)
				rsp_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
					: $urandom_range(1, 3);
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		path_rsp_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t: unexpected result word status=%0d", $time, rsp.status);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.status !== e.st || rsp.reachable !== e.reach
						|| rsp.distance !== e.dval || rsp.has_pred !== e.hp
						|| rsp.pred_node !== e.pn) begin
					$display("%0t: mismatch exp st=%0d r=%0d d=%0d hp=%0d p=%0d",
						$time, e.st, e.reach, e.dval, e.hp, e.pn);
					$display("%0t:          act st=%0d r=%0d d=%0d hp=%0d p=%0d",
						$time, rsp.status, rsp.reachable, rsp.distance,
						rsp.has_pred, rsp.pred_node);
					errors++;
				end
			end
		end
	end

	// stop on a long stretch with no word moving
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic read_nodes(int count);
		for (int i = 0; i < count; i++)
			send_word(spfa_pkg::CMD_READ, $urandom_range(0, active_nodes() - 1), 0, 0);
	endtask

	task automatic test_reset_reads();
		send_word(spfa_pkg::CMD_READ, 0, 0, 0);
		send_word(spfa_pkg::CMD_READ, 63, 0, 0);
		send_word(spfa_pkg::CMD_RUN, 5, 0, 0);
		send_word(spfa_pkg::CMD_READ, 5, 0, 0);
	endtask

	task automatic test_extreme_weights();
		set_nodes(7'd4);
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
		send_word(spfa_pkg::CMD_ADD, 0, 1, 32767);
		send_word(spfa_pkg::CMD_ADD, 1, 2, -32768);
		send_word(spfa_pkg::CMD_ADD, 0, 2, 32767);
		send_word(spfa_pkg::CMD_ADD, 2, 3, -1);
		send_word(spfa_pkg::CMD_RUN, 0, 0, 0);
		for (int i = 0; i < 4; i++) send_word(spfa_pkg::CMD_READ, i, 0, 0);
	endtask

	task automatic test_bad_index();
		send_word(spfa_pkg::CMD_ADD, 4, 0, 1);
		send_word(spfa_pkg::CMD_ADD, 0, 63, 1);
		send_word(spfa_pkg::CMD_RUN, 63, 0, 0);
		send_word(spfa_pkg::CMD_READ, 4, 0, 0);
	endtask

	task automatic test_clear_keeps_results();
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
		send_word(spfa_pkg::CMD_READ, 3, 0, 0);
		send_word(spfa_pkg::CMD_RUN, 1, 0, 0);
		send_word(spfa_pkg::CMD_READ, 3, 0, 0);
	endtask

	task automatic test_negative_cycle();
		set_nodes(7'd3);
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
		send_word(spfa_pkg::CMD_ADD, 0, 1, 2);
		send_word(spfa_pkg::CMD_ADD, 1, 2, -5);
		send_word(spfa_pkg::CMD_ADD, 2, 1, 1);
		send_word(spfa_pkg::CMD_RUN, 0, 0, 0);
		for (int i = 0; i < 3; i++) send_word(spfa_pkg::CMD_READ, i, 0, 0);
	endtask

	task automatic test_stale_edges();
		set_nodes(7'd16);
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
		send_word(spfa_pkg::CMD_ADD, 0, 12, 3);
		send_word(spfa_pkg::CMD_ADD, 12, 1, 3);
		send_word(spfa_pkg::CMD_ADD, 0, 1, 9);
		set_nodes(7'd8);
		send_word(spfa_pkg::CMD_RUN, 0, 0, 0);
		send_word(spfa_pkg::CMD_READ, 1, 0, 0);
		set_nodes(7'd16);
		send_word(spfa_pkg::CMD_READ, 12, 0, 0);
	endtask

	task automatic test_count_limits();
		set_nodes(7'd0);
		send_word(spfa_pkg::CMD_ADD, 0, 0, 7);
		send_word(spfa_pkg::CMD_ADD, 0, 1, 7);
		send_word(spfa_pkg::CMD_RUN, 0, 0, 0);
		send_word(spfa_pkg::CMD_READ, 0, 0, 0);
		send_word(spfa_pkg::CMD_READ, 1, 0, 0);
		set_nodes(7'd127);
		send_word(spfa_pkg::CMD_READ, 63, 0, 0);
		set_nodes(7'd64);
		send_word(spfa_pkg::CMD_READ, 63, 0, 0);
	endtask

	task automatic test_full_store();
		set_nodes(7'd4);
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
		for (int i = 0; i < spfa_pkg::EDGES + 2; i++)
			send_word(spfa_pkg::CMD_ADD, $urandom_range(0, 3), $urandom_range(0, 3),
				$urandom_range(0, 50));
		send_word(spfa_pkg::CMD_RUN, 0, 0, 0);
		read_nodes(4);
		send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
	endtask

	// random graphs: mostly well formed load-run-read sequences
	task automatic test_random_graphs();
		int n, m, w, a, b;
		bit small_w;
		while (words_sent < 1300) begin
			calm = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 9))
				0:       set_nodes($urandom_range(0, 127));
				1:       set_nodes(7'd64);
				default: set_nodes($urandom_range(2, 16));
			endcase
			n = active_nodes();
			small_w = (n > 16) || ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 7) != 0) send_word(spfa_pkg::CMD_CLEAR, 0, 0, 0);
			m = $urandom_range(0, (n > 16) ? 40 : 30);
			for (int i = 0; i < m; i++) begin
				a = $urandom_range(0, n - 1);
				b = $urandom_range(0, n - 1);
				if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 63);
				if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 63);
				w = small_w ? $urandom_range(0, 100)
					: $signed(16'($urandom_range(0, 65535)));
				if (small_w && $urandom_range(0, 9) == 0) w = -$urandom_range(0, 3);
				send_word(spfa_pkg::CMD_ADD, a, b, w);
			end
			a = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, n - 1);
			send_word(spfa_pkg::CMD_RUN, a, 0, 0);
			read_nodes($urandom_range(3, 10));
			if ($urandom_range(0, 4) == 0)
				send_word(spfa_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 65535));
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.cmd = spfa_pkg::CMD_CLEAR;
		req.node_a = '0;
		req.node_b = '0;
		req.weight = '0;
		rsp.ready = 1'b0;
		node_cnt = spfa_pkg::NODE_CNT_RESET;
		edge_total = 0;
		errors = 0;
		words_sent = 0;
		idle_cycles = 0;
		rsp_hold = 0;
		calm = 1'b0;
		for (int i = 0; i < spfa_pkg::NODES; i++) begin
			node_reach[i] = 1'b0;
			node_prev_ok[i] = 1'b0;
			in_list[i] = 1'b0;
			push_count[i] = 0;
			node_dist[i] = 0;
			node_prev[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_reads();
		test_extreme_weights();
		test_bad_index();
		test_clear_keeps_results();
		test_negative_cycle();
		test_stale_edges();
		test_count_limits();
		test_full_store();
		test_random_graphs();

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rsp.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
